// ----- sv/htse_pkg.sv -----
// ----------------------------------------------------------------------------
// htse_pkg: shared definitions for the homing-then-sine effort sequencer
// Mode codes, configuration register indexes, parameter defaults and the
// quarter-wave sine entry generator used to build the sine ROM.
// ----------------------------------------------------------------------------
package htse_pkg;

    // Parameter defaults
    localparam int NUM_JOINTS_DEF      = 4;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_INDEX_BITS_DEF = 10;

    // Operating modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_HOMING = 2'd1;
    localparam logic [1:0] MODE_SINE   = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_HOMING_EFFORT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_TABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_TABLE    = 3'd4;

    // 1.0 in Q11.12
    localparam logic [23:0] ONE_Q12 = 24'd4096;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Shift-and-subtract long division, used only while building the table
    function automatic logic [63:0] div_by_small(input logic [63:0] num,
                                                 input logic [7:0]  den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(den))
            begin
                rem    = rem - 64'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine entry k, Q1.15 saturated to 32767. Evaluated at
    // elaboration only: Taylor series of sin(x) in Q30, seven terms.
    function automatic logic [14:0] sine_entry(input int unsigned k,
                                               input int unsigned sib);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [7:0]  div;
        x    = (HALF_PI_Q30 * 64'(k)) >> sib;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++)
        begin
            case (n)
                1:       div = 8'd6;
                2:       div = 8'd20;
                3:       div = 8'd42;
                4:       div = 8'd72;
                5:       div = 8'd110;
                default: div = 8'd156;
            endcase
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_by_small(term, div);
            if ((n & 1) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

// ----- sv/htse_sine_rom.sv -----
// ----------------------------------------------------------------------------
// htse_sine_rom: quarter-wave sine ROM
// Holds sin over a quarter turn, 2^SINE_INDEX_BITS + 1 entries of Q1.15,
// built at elaboration. One read port with registered data.
// ----------------------------------------------------------------------------
module htse_sine_rom #(
    parameter int SINE_INDEX_BITS = htse_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic                     clk,
    input  logic [SINE_INDEX_BITS:0] rd_addr,
    output logic [14:0]              rd_data
);

    localparam int TBL_N = 1 << SINE_INDEX_BITS;

    logic [14:0] qtab [TBL_N+1];

    // one constant entry per address
    for (genvar k = 0; k <= TBL_N; k++)
    begin : g_qtab
        localparam logic [14:0] ENTRY = htse_pkg::sine_entry(k, SINE_INDEX_BITS);
        assign qtab[k] = ENTRY;
    end

    logic [14:0] data_reg;

    // registered read
    always_ff @(posedge clk)
    begin
        data_reg <= qtab[rd_addr];
    end

    assign rd_data = data_reg;

endmodule

// ----- sv/homing_then_sine_effort_sequencer.sv -----
// ----------------------------------------------------------------------------
// homing_then_sine_effort_sequencer: three-mode joint effort sequencer
// Idle / homing / sine effort commands for up to four joints, one command
// word per joint position sample, with a shared multiplier and sine ROM.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words (joint, position, enable, period, last_in_tick) enter on
//    in_valid/in_ready. One sample at a time is worked on; in_ready is high
//    only while the sequencer waits for a word.
//  - One result word per input leaves on out_valid/out_ready from an output
//    register, so a new input is taken while a result still waits.
//  - Steps: idle, homing and held results are evaluated, then written back;
//    a sine result goes through the frequency x period product, phase
//    update and ROM read, amplitude x sine product and rounding. The next word
//    is taken the cycle after the result is written to the output register,
//    so words are not overlapped, a limit set by the single shared
//    25x25 multiplier and the registered ROM read.
//  - A stalled receiver holds the finished result in the output register;
//    the sequencer then waits in its write-back step until it is free.
//  - cfg_write writes cfg_data into register cfg_index in the same edge;
//    write only while no sample is in flight.
//  - Reset (rst_n low, async) clears the mode to idle, closes the tick and
//    zeroes the config registers, phases and held outputs. No clearing pass.
// ----------------------------------------------------------------------------
module homing_then_sine_effort_sequencer #(
    parameter int NUM_JOINTS      = htse_pkg::NUM_JOINTS_DEF,
    parameter int PHASE_BITS      = htse_pkg::PHASE_BITS_DEF,
    parameter int SINE_INDEX_BITS = htse_pkg::SINE_INDEX_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [htse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htse_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      joint,
    input  logic signed [23:0]              position,
    input  logic                            enable,
    input  logic [23:0]                     period,
    input  logic                            last_in_tick,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      joint_out,
    output logic signed [15:0]              effort,
    output logic                            online,
    output logic [1:0]                      mode,
    output logic                            last_out
);

    localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int STEP_SHIFT = 32 - PHASE_BITS;
    localparam int TBL_N      = 1 << SINE_INDEX_BITS;
    localparam logic [SINE_INDEX_BITS:0] TBL_N_V = (SINE_INDEX_BITS+1)'(TBL_N);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_PHASE = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [14:0] homing_effort_reg;
    logic [22:0] pos_tol_reg;
    logic [3:0]  target_mask_reg;
    logic [63:0] amp_table_reg;
    logic [63:0] freq_table_reg;

    // tick and mode state
    logic [1:0] mode_reg;
    logic [1:0] tick_mode_reg;
    logic       tick_open_reg;
    logic       tick_enable_reg;
    logic       reach_reg;

    // per-joint state
    logic [PHASE_BITS-1:0] phase_reg [NUM_JOINTS];
    logic signed [15:0]    held_eff_reg [NUM_JOINTS];
    logic                  held_cw_reg [NUM_JOINTS];

    // latched sample
    logic [1:0]         joint_reg;
    logic signed [23:0] pos_reg;
    logic [23:0]        period_reg;
    logic               last_reg;

    // datapath
    logic signed [49:0] prod_reg;
    logic               neg_reg;
    logic signed [15:0] res_eff_reg;
    logic               res_cw_reg;

    // output register
    logic               out_valid_reg;
    logic [1:0]         joint_out_reg;
    logic signed [15:0] effort_reg;
    logic               cw_out_reg;
    logic [1:0]         mode_out_reg;
    logic               last_out_reg;

    logic                   accept;
    logic                   wb_go;
    logic [JIDX_W-1:0]      jidx;
    logic                   joint_ok;
    logic                   target;
    logic [23:0]            pos_mag;
    logic                   pos_gt0;
    logic [15:0]            f_sel;
    logic [15:0]            amp_sel;
    logic                   sine_path;
    logic signed [15:0]     he_pos;
    logic signed [15:0]     eval_eff;
    logic                   eval_cw;
    logic                   reach_hit;
    logic signed [24:0]     mul_a;
    logic signed [24:0]     mul_b;
    logic signed [49:0]     mul_p;
    logic signed [15:0]     sine_val;
    logic [PHASE_BITS-1:0]  step;
    logic [PHASE_BITS-1:0]  phase_new;
    logic [1:0]             quad;
    logic [SINE_INDEX_BITS-1:0] tidx;
    logic [SINE_INDEX_BITS:0]   rom_addr;
    logic [14:0]            rom_q;
    logic signed [32:0]     rsum;
    logic signed [32:0]     rsh;
    logic signed [15:0]     round_eff;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign wb_go  = (state_reg == S_WB) && (!out_valid_reg || out_ready);

    // joint decode and field selection
    assign jidx     = joint_reg[JIDX_W-1:0];
    assign joint_ok = (int'(joint_reg) < NUM_JOINTS);
    assign target   = target_mask_reg[joint_reg];
    assign pos_mag  = pos_reg[23] ? (~pos_reg + 24'd1) : pos_reg;
    assign pos_gt0  = !pos_reg[23] && (pos_reg != 24'sd0);
    assign f_sel    = freq_table_reg[{joint_reg, 4'b0000} +: 16];
    assign amp_sel  = amp_table_reg[{joint_reg, 4'b0000} +: 16];
    assign he_pos   = $signed({1'b0, homing_effort_reg});
    assign sine_path = (tick_mode_reg == htse_pkg::MODE_SINE) && tick_enable_reg
                       && target && joint_ok;

    // idle / homing / held result
    always_comb
    begin
        eval_eff  = 16'sd0;
        eval_cw   = 1'b0;
        reach_hit = 1'b0;
        if (joint_ok)
        begin
            eval_eff = held_eff_reg[jidx];
            eval_cw  = held_cw_reg[jidx];
            case (tick_mode_reg)
                htse_pkg::MODE_IDLE:
                begin
                    eval_eff = 16'sd0;
                    eval_cw  = (pos_mag >= htse_pkg::ONE_Q12);
                end
                htse_pkg::MODE_HOMING:
                begin
                    if (target)
                    begin
                        eval_eff = pos_gt0 ? -he_pos : he_pos;
                        if (pos_mag < {1'b0, pos_tol_reg})
                        begin
                            eval_eff  = 16'sd0;
                            reach_hit = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // shared multiplier: frequency x period, then amplitude x sine
    assign sine_val = neg_reg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

    always_comb
    begin
        if (state_reg == S_MUL2)
        begin
            mul_a = {{9{amp_sel[15]}}, amp_sel};
            mul_b = {{9{sine_val[15]}}, sine_val};
        end
        else
        begin
            mul_a = $signed({9'b0, f_sel});
            mul_b = $signed({1'b0, period_reg});
        end
    end

    assign mul_p = mul_a * mul_b;

    // phase advance and ROM address
    assign step      = prod_reg[31:STEP_SHIFT];
    assign phase_new = phase_reg[jidx] + step;
    assign quad      = phase_new[PHASE_BITS-1 -: 2];
    assign tidx      = phase_new[PHASE_BITS-3 -: SINE_INDEX_BITS];
    assign rom_addr  = quad[0] ? (TBL_N_V - {1'b0, tidx}) : {1'b0, tidx};

    htse_sine_rom #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .rd_addr (rom_addr),
        .rd_data (rom_q)
    );

    // round half up, saturate to 16 bit
    assign rsum = 33'(signed'(prod_reg[31:0])) + 33'sd16384;
    assign rsh  = rsum >>> 15;

    always_comb
    begin
        if (rsh > 33'sd32767)
        begin
            round_eff = 16'sd32767;
        end
        else if (rsh < -33'sd32768)
        begin
            round_eff = -16'sd32768;
        end
        else
        begin
            round_eff = rsh[15:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EVAL;
            S_EVAL:  state_next = sine_path ? S_PHASE : S_WB;
            S_PHASE: state_next = S_MUL2;
            S_MUL2:  state_next = S_ROUND;
            S_ROUND: state_next = S_WB;
            S_WB:    if (wb_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state, config, tick and per-joint state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            homing_effort_reg <= '0;
            pos_tol_reg       <= '0;
            target_mask_reg   <= '0;
            amp_table_reg     <= '0;
            freq_table_reg    <= '0;
            mode_reg          <= htse_pkg::MODE_IDLE;
            tick_mode_reg     <= htse_pkg::MODE_IDLE;
            tick_open_reg     <= 1'b0;
            tick_enable_reg   <= 1'b0;
            reach_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                phase_reg[i]    <= '0;
                held_eff_reg[i] <= '0;
                held_cw_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // config writes
            if (cfg_write)
            begin
                case (cfg_index)
                    htse_pkg::REG_HOMING_EFFORT: homing_effort_reg <= cfg_data[14:0];
                    htse_pkg::REG_POS_TOLERANCE: pos_tol_reg       <= cfg_data[22:0];
                    htse_pkg::REG_TARGET_MASK:   target_mask_reg   <= cfg_data[3:0];
                    htse_pkg::REG_AMP_TABLE:     amp_table_reg     <= cfg_data;
                    htse_pkg::REG_FREQ_TABLE:    freq_table_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // first word of a tick latches mode and enable
            if (accept && !tick_open_reg)
            begin
                tick_open_reg   <= 1'b1;
                tick_mode_reg   <= mode_reg;
                tick_enable_reg <= enable;
                reach_reg       <= 1'b0;
            end

            if ((state_reg == S_EVAL) && reach_hit)
            begin
                reach_reg <= 1'b1;
            end

            if (state_reg == S_PHASE)
            begin
                phase_reg[jidx] <= phase_new;
            end

            // write back: held values, output word, end of tick
            if (wb_go)
            begin
                out_valid_reg <= 1'b1;
                if (joint_ok)
                begin
                    held_eff_reg[jidx] <= res_eff_reg;
                    held_cw_reg[jidx]  <= res_cw_reg;
                end
                if (last_reg)
                begin
                    tick_open_reg <= 1'b0;
                    case (tick_mode_reg)
                        htse_pkg::MODE_IDLE:
                        begin
                            if (tick_enable_reg) mode_reg <= htse_pkg::MODE_HOMING;
                        end
                        htse_pkg::MODE_HOMING:
                        begin
                            if (reach_reg) mode_reg <= htse_pkg::MODE_SINE;
                        end
                        default:
                        begin
                            if (!tick_enable_reg) mode_reg <= htse_pkg::MODE_IDLE;
                        end
                    endcase
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            joint_reg  <= joint;
            pos_reg    <= position;
            period_reg <= period;
            last_reg   <= last_in_tick;
        end
        if ((state_reg == S_EVAL) || (state_reg == S_MUL2))
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_PHASE)
        begin
            neg_reg <= quad[1];
        end
        if (state_reg == S_EVAL)
        begin
            res_eff_reg <= eval_eff;
            res_cw_reg  <= eval_cw;
        end
        if (state_reg == S_ROUND)
        begin
            res_eff_reg <= round_eff;
        end
        if (wb_go)
        begin
            joint_out_reg <= joint_reg;
            effort_reg    <= res_eff_reg;
            cw_out_reg    <= res_cw_reg;
            mode_out_reg  <= tick_mode_reg;
            last_out_reg  <= last_reg;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign joint_out    = joint_out_reg;
    assign effort       = effort_reg;
    assign online       = cw_out_reg;
    assign mode         = mode_out_reg;
    assign last_out     = last_out_reg;

    // checks
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EVAL))
        else $error("accepted word did not start evaluation");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (mode == htse_pkg::MODE_IDLE)) |-> (effort == 16'sd0))
        else $error("idle result with nonzero effort");

    a_no_idle_to_sine: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == htse_pkg::MODE_IDLE) |=> (mode_reg != htse_pkg::MODE_SINE))
        else $error("mode jumped from idle to sine");

    a_no_sine_to_homing: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == htse_pkg::MODE_SINE) |=> (mode_reg != htse_pkg::MODE_HOMING))
        else $error("mode jumped from sine to homing");

endmodule

// ----- bench/htse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htse_checker: effort command predictor and scoreboard
// Watches the configuration port and both word channels of the sequencer,
// keeps its own copy of the mode, tick, phase and hold state, predicts one
// command word per accepted sample and compares it field by field with the
// oldest prediction when the command word leaves the block.
// ----------------------------------------------------------------------------
module htse_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [htse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      joint,
    input  logic signed [23:0]              position,
    input  logic                            enable,
    input  logic [23:0]                     period,
    input  logic                            last_in_tick,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      joint_out,
    input  logic signed [15:0]              effort,
    input  logic                            online,
    input  logic [1:0]                      mode,
    input  logic                            last_out,
    output int                              fail_count,
    output int                              expect_left,
    output int                              words_checked,
    output int                              homing_words,
    output int                              sine_words
);

    localparam int NUM_J     = htse_pkg::NUM_JOINTS_DEF;
    localparam int PH_BITS   = htse_pkg::PHASE_BITS_DEF;
    localparam int SIB       = htse_pkg::SINE_INDEX_BITS_DEF;
    localparam int TBL_N     = 1 << SIB;
    localparam int MAX_PRINT = 40;

    typedef struct packed {
        logic [1:0]         joint;
        logic signed [15:0] effort;
        logic               control;
        logic [1:0]         mode;
        logic               last;
    } effort_cmd_t;

    // shadow configuration
    logic [14:0] cfg_homing_effort;
    logic [22:0] cfg_tolerance;
    logic [3:0]  cfg_targets;
    logic [63:0] cfg_amps;
    logic [63:0] cfg_freqs;

    // sequencer state
    logic [1:0]         mode_next;
    logic [1:0]         tick_mode_q;
    logic               tick_busy;
    logic               tick_run;
    logic               homed_seen;
    logic [PH_BITS-1:0] phase_turns [NUM_J];
    logic signed [15:0] held_eff [NUM_J];
    logic               held_cw [NUM_J];

    effort_cmd_t pending_cmds [$];
    int          quarter_wave [0:TBL_N];

    initial
    begin
        fail_count    = 0;
        expect_left   = 0;
        words_checked = 0;
        homing_words  = 0;
        sine_words    = 0;
    end

    // quarter-wave sine, Q1.15, from a seven-term Taylor series in Q30
    initial
    begin : build_quarter_wave
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        for (int k = 0; k <= TBL_N; k++)
        begin
            x    = (htse_pkg::HALF_PI_Q30 * 64'(k)) >> SIB;
            term = x;
            acc  = x;
            for (int n = 1; n <= 6; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            acc = (acc + 64'd16384) >> 15;
            quarter_wave[k] = (acc > 64'd32767) ? 32767 : int'(acc);
        end
    end

    function automatic int sine_q15(input logic [PH_BITS-1:0] ph);
        logic [1:0] quad;
        int         idx;
        int         v;
        quad = ph[PH_BITS-1 -: 2];
        idx  = int'(ph[PH_BITS-3 -: SIB]);
        v    = quad[0] ? quarter_wave[TBL_N - idx] : quarter_wave[idx];
        return quad[1] ? -v : v;
    endfunction

    // one sample in, one predicted command word out
    function automatic void predict_command(input logic [1:0] j,
                                            input logic signed [23:0] pos,
                                            input logic en,
                                            input logic [23:0] per,
                                            input logic lst);
        effort_cmd_t        cmd;
        longint             mag;
        logic signed [15:0] eff;
        logic               cw;
        logic [15:0]        freq;
        logic signed [15:0] amp;
        logic [39:0]        full_step;
        longint             prod;
        if (!tick_busy)
        begin
            tick_busy   = 1'b1;
            tick_mode_q = mode_next;
            tick_run    = en;
            homed_seen  = 1'b0;
        end
        mag = (pos < 0) ? -longint'(pos) : longint'(pos);
        eff = '0;
        cw  = 1'b0;
        if (int'(j) < NUM_J)
        begin
            eff = held_eff[j];
            cw  = held_cw[j];
            case (tick_mode_q)
                htse_pkg::MODE_IDLE:
                begin
                    eff = '0;
                    cw  = (mag >= longint'(htse_pkg::ONE_Q12));
                end
                htse_pkg::MODE_HOMING:
                begin
                    if (cfg_targets[j])
                    begin
                        eff = 16'(cfg_homing_effort);
                        if (pos > 0)
                        begin
                            eff = -eff;
                        end
                        if (mag < longint'(cfg_tolerance))
                        begin
                            eff        = '0;
                            homed_seen = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (tick_run && cfg_targets[j])
                    begin
                        freq           = cfg_freqs[16 * j +: 16];
                        amp            = cfg_amps[16 * j +: 16];
                        full_step      = 40'(freq) * 40'(per);
                        phase_turns[j] = phase_turns[j]
                                         + PH_BITS'(full_step[31:0] >> (32 - PH_BITS));
                        prod = longint'(amp) * longint'(sine_q15(phase_turns[j]));
                        prod = (prod + 16384) >>> 15;
                        if (prod > 32767)
                        begin
                            eff = 16'sh7fff;
                        end
                        else if (prod < -32768)
                        begin
                            eff = 16'sh8000;
                        end
                        else
                        begin
                            eff = 16'(prod);
                        end
                    end
                end
            endcase
            held_eff[j] = eff;
            held_cw[j]  = cw;
        end
        cmd.joint   = j;
        cmd.effort  = eff;
        cmd.control = cw;
        cmd.mode    = tick_mode_q;
        cmd.last    = lst;
        pending_cmds = {pending_cmds, cmd};
        // mode change takes effect at the end of the tick
        if (lst)
        begin
            tick_busy = 1'b0;
            case (tick_mode_q)
                htse_pkg::MODE_IDLE:
                begin
                    if (tick_run)
                    begin
                        mode_next = htse_pkg::MODE_HOMING;
                    end
                end
                htse_pkg::MODE_HOMING:
                begin
                    if (homed_seen)
                    begin
                        mode_next = htse_pkg::MODE_SINE;
                    end
                end
                default:
                begin
                    if (!tick_run)
                    begin
                        mode_next = htse_pkg::MODE_IDLE;
                    end
                end
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINT)
        begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic check_command;
        effort_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            report_mismatch("unexpected command word (joint)", int'(joint_out), -1);
        end
        else
        begin
            want = pending_cmds.pop_front();
            words_checked++;
            if (want.mode == htse_pkg::MODE_HOMING)
            begin
                homing_words++;
            end
            if (want.mode == htse_pkg::MODE_SINE)
            begin
                sine_words++;
            end
            if (joint_out !== want.joint)
            begin
                report_mismatch("joint_out", int'(joint_out), int'(want.joint));
            end
            if (effort !== want.effort)
            begin
                report_mismatch("effort", int'(effort), int'(want.effort));
            end
            if (online !== want.control)
            begin
                report_mismatch("online", int'(online), int'(want.control));
            end
            if (mode !== want.mode)
            begin
                report_mismatch("mode", int'(mode), int'(want.mode));
            end
            if (last_out !== want.last)
            begin
                report_mismatch("last_out", int'(last_out), int'(want.last));
            end
        end
    endtask

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_homing_effort = '0;
            cfg_tolerance     = '0;
            cfg_targets       = '0;
            cfg_amps          = '0;
            cfg_freqs         = '0;
            mode_next         = htse_pkg::MODE_IDLE;
            tick_mode_q       = htse_pkg::MODE_IDLE;
            tick_busy         = 1'b0;
            tick_run          = 1'b0;
            homed_seen        = 1'b0;
            for (int j = 0; j < NUM_J; j++)
            begin
                phase_turns[j] = '0;
                held_eff[j]    = '0;
                held_cw[j]     = 1'b0;
            end
            pending_cmds.delete();
            expect_left = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    htse_pkg::REG_HOMING_EFFORT: cfg_homing_effort = cfg_data[14:0];
                    htse_pkg::REG_POS_TOLERANCE: cfg_tolerance     = cfg_data[22:0];
                    htse_pkg::REG_TARGET_MASK:   cfg_targets       = cfg_data[3:0];
                    htse_pkg::REG_AMP_TABLE:     cfg_amps          = cfg_data;
                    htse_pkg::REG_FREQ_TABLE:    cfg_freqs         = cfg_data;
                    default:           ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                check_command();
            end
            if (in_valid && in_ready)
            begin
                predict_command(joint, position, enable, period, last_in_tick);
            end
            expect_left = pending_cmds.size();
        end
    end

endmodule

// ----- bench/homing_then_sine_effort_sequencer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homing_then_sine_effort_sequencer_tb: stimulus and verdict
// Drives directed ticks through idle, homing and sine, then random ticks
// over several register settings (zero and full-scale among them) with
// random gaps and output stalls, one long output hold-off and a quiet
// final stretch. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module homing_then_sine_effort_sequencer_tb;

    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 8;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 300;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [htse_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [htse_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [1:0]                      joint;
    logic signed [23:0]              position;
    logic                            enable;
    logic [23:0]                     period;
    logic                            last_in_tick;
    logic                            out_valid;
    logic                            out_ready;
    logic [1:0]                      joint_out;
    logic signed [15:0]              effort;
    logic                            online;
    logic [1:0]                      mode;
    logic                            last_out;

    int          fail_count;
    int          expect_left;
    int          words_checked;
    int          homing_words;
    int          sine_words;
    int          words_sent = 0;
    int          settings_used = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    logic [22:0] cur_tol = '0;

    homing_then_sine_effort_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .joint        (joint),
        .position     (position),
        .enable       (enable),
        .period       (period),
        .last_in_tick (last_in_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .joint_out    (joint_out),
        .effort       (effort),
        .online       (online),
        .mode         (mode),
        .last_out     (last_out)
    );

    htse_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .joint         (joint),
        .position      (position),
        .enable        (enable),
        .period        (period),
        .last_in_tick  (last_in_tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .joint_out     (joint_out),
        .effort        (effort),
        .online        (online),
        .mode          (mode),
        .last_out      (last_out),
        .fail_count    (fail_count),
        .expect_left   (expect_left),
        .words_checked (words_checked),
        .homing_words  (homing_words),
        .sine_words    (sine_words)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off, none when quiet
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    // offer one sample word and hold it until taken
    task automatic send_word(input logic [1:0] j, input logic signed [23:0] pos,
                             input logic en, input logic [23:0] per, input logic lst);
        in_valid     <= 1'b1;
        joint        <= j;
        position     <= pos;
        enable       <= en;
        period       <= per;
        last_in_tick <= lst;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // stop offering, let every command word come out, then let the block settle
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expect_left != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_settings(input logic [14:0] he, input logic [22:0] tol,
                                  input logic [3:0] targets, input logic [63:0] amps,
                                  input logic [63:0] freqs);
        logic [htse_pkg::CFG_IDX_W-1:0]  regs [5];
        logic [htse_pkg::CFG_DATA_W-1:0] vals [5];
        regs = '{htse_pkg::REG_HOMING_EFFORT, htse_pkg::REG_POS_TOLERANCE,
                 htse_pkg::REG_TARGET_MASK, htse_pkg::REG_AMP_TABLE,
                 htse_pkg::REG_FREQ_TABLE};
        vals = '{64'(he), 64'(tol), 64'(targets), amps, freqs};
        for (int r = 0; r < 5; r++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur_tol = tol;
        settings_used++;
    endtask

    // positions: full range, extremes, around the tolerance, near zero
    function automatic logic signed [23:0] pick_position();
        int sel;
        int m;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            return 24'($urandom);
        end
        else if (sel < 45)
        begin
            case ($urandom_range(0, 8))
                0:       return 24'sh800000;
                1:       return 24'sh7fffff;
                2:       return 24'sd0;
                3:       return 24'sd1;
                4:       return -24'sd1;
                5:       return 24'sd4096;
                6:       return -24'sd4096;
                7:       return 24'sd4095;
                default: return -24'sd4095;
            endcase
        end
        else if (sel < 75)
        begin
            m = int'(cur_tol) + int'($urandom_range(0, 5)) - 3;
            if (m < 0)
            begin
                m = 0;
            end
            if (m > 8388607)
            begin
                m = 8388607;
            end
            return $urandom_range(0, 1) ? -24'(m) : 24'(m);
        end
        else
        begin
            m = int'($urandom_range(0, 8192));
            return $urandom_range(0, 1) ? -24'(m) : 24'(m);
        end
    endfunction

    function automatic logic [23:0] pick_period();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return 24'hffffff;
        end
        else if (sel == 1)
        begin
            return 24'(4'($urandom) & 4'h1);
        end
        else if (sel < 4)
        begin
            return 24'($urandom_range(0, 4095));
        end
        return 24'($urandom);
    endfunction

    // one tick of 1 to 6 samples; enable only counts on the first one
    task automatic send_random_tick;
        int   n;
        logic tick_en;
        n       = $urandom_range(1, 6);
        tick_en = ($urandom_range(0, 99) < 85);
        for (int k = 0; k < n; k++)
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            send_word(2'($urandom_range(0, 3)), pick_position(),
                      (k == 0) ? tick_en : 1'($urandom_range(0, 1)),
                      pick_period(), (k == n - 1));
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= htse_pkg::REG_HOMING_EFFORT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        joint        <= '0;
        position     <= '0;
        enable       <= 1'b0;
        period       <= '0;
        last_in_tick <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: targets 0 and 2, tolerance 1.0, negative full-scale amp on joint 2
        write_settings(15'd1234, 23'd4096, 4'b0101,
                       {16'h3039, 16'h8000, 16'hfc18, 16'h7fff},
                       {16'h0100, 16'hffff, 16'h1234, 16'h0800});
        // idle tick, enable low: online threshold and position extremes
        send_word(2'd0, 24'sd4096, 1'b0, 24'h100000, 1'b0);
        send_word(2'd1, 24'sd4095, 1'b1, 24'h100000, 1'b0);
        send_word(2'd2, 24'sh800000, 1'b0, 24'h100000, 1'b0);
        send_word(2'd3, 24'sh7fffff, 1'b0, 24'h100000, 1'b1);
        // idle tick with enable: go homing
        send_word(2'd0, -24'sd4096, 1'b1, 24'h000400, 1'b0);
        send_word(2'd1, -24'sd4095, 1'b0, 24'h000400, 1'b1);
        // homing, enable low is ignored; nobody inside tolerance yet
        send_word(2'd0, 24'sd100000, 1'b0, 24'h000001, 1'b0);
        send_word(2'd1, 24'sd5, 1'b0, 24'h000001, 1'b0);
        send_word(2'd2, -24'sd50000, 1'b0, 24'h000001, 1'b0);
        send_word(2'd3, 24'sh7fffff, 1'b0, 24'h000001, 1'b0);
        send_word(2'd0, 24'sd4096, 1'b0, 24'h000001, 1'b1);
        // homing: joint 2 reaches, tick ends in sine
        send_word(2'd2, 24'sd4095, 1'b1, 24'h000001, 1'b0);
        send_word(2'd0, 24'sh800000, 1'b0, 24'h000001, 1'b1);
        // sine at full period, joint 0 repeated, non-targets held
        send_word(2'd0, 24'sd77, 1'b1, 24'hffffff, 1'b0);
        send_word(2'd1, 24'sd77, 1'b0, 24'hffffff, 1'b0);
        send_word(2'd2, 24'sd77, 1'b0, 24'hffffff, 1'b0);
        send_word(2'd0, 24'sd77, 1'b0, 24'hffffff, 1'b0);
        send_word(2'd3, 24'sd77, 1'b0, 24'hffffff, 1'b1);
        // sine with zero period
        send_word(2'd2, -24'sd9, 1'b1, 24'h000000, 1'b0);
        send_word(2'd0, -24'sd9, 1'b0, 24'h000000, 1'b1);
        // enable dropped: held outputs, back to idle
        send_word(2'd0, 24'sd0, 1'b0, 24'h123456, 1'b0);
        send_word(2'd2, 24'sd0, 1'b1, 24'h123456, 1'b1);
        send_word(2'd1, 24'sd12345, 1'b0, 24'h123456, 1'b1);
        wait_drained();

        // random ticks over several register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: write_settings(15'h7fff, 23'h7fffff, 4'hf,
                                  {16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, '1);
                2: write_settings('0, '0, '0, '0, '0);
                default:
                    write_settings(15'($urandom),
                                   ($urandom_range(0, 3) == 0) ? 23'($urandom)
                                                               : 23'($urandom_range(0, 65536)),
                                   4'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            if (ph == 3)
            begin
                hold_req = 1'b1;
            end
            if (ph == NUM_PHASES - 1)
            begin
                quiet = 1'b1;
            end
            while (words_sent < 23 + (ph + 1) * PHASE_ITEMS)
            begin
                send_random_tick();
            end
            wait_drained();
        end

        $display("run covered %0d sample words over %0d register settings",
                 words_sent, settings_used);
        $display("checked %0d command words: %0d in homing, %0d in sine",
                 words_checked, homing_words, sine_words);
        if (fail_count == 0 && expect_left == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/htse_pkg.sv
sv/htse_sine_rom.sv
sv/homing_then_sine_effort_sequencer.sv
bench/htse_checker.sv
bench/homing_then_sine_effort_sequencer_tb.sv
